// File: design/mbb_pkg.sv
// Package for the largest-blob area block: sizes, codes and controller/datapath structs.
`timescale 1ns / 1ps
package mbb_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int SIZE_W          = 7;
   localparam int ROW_COUNT_RESET = 64;
   localparam int COL_COUNT_RESET = 64;
   localparam int AREA_W          = 13;
   localparam int AREA_MAX        = (2 ** AREA_W) - 1;

   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int GRID_DEPTH = 2 ** ADDR_W;

   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
   localparam int QIDX_W   = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
   localparam int QCNT_W   = $clog2(CELL_CAP + 1);

   // grid store cell codes
   localparam int GRID_W = 2;
   localparam logic [GRID_W-1:0] GRID_WATER   = 2'd0;
   localparam logic [GRID_W-1:0] GRID_LAND    = 2'd1;
   localparam logic [GRID_W-1:0] GRID_VISITED = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   // neighbor probe order: down, up, right, left, then a final check-only step
   localparam int NBR_W = 3;
   localparam logic [NBR_W-1:0] NBR_DOWN  = 3'd0;
   localparam logic [NBR_W-1:0] NBR_UP    = 3'd1;
   localparam logic [NBR_W-1:0] NBR_RIGHT = 3'd2;
   localparam logic [NBR_W-1:0] NBR_LEFT  = 3'd3;
   localparam logic [NBR_W-1:0] NBR_END   = 3'd4;

   typedef struct packed {
      logic load_cell;
      logic scan_init;
      logic scan_read;
      logic scan_next;
      logic fill_start;
      logic pop_read;
      logic pop_latch;
      logic nbr_step;
      logic comp_done;
      logic rsp_load;
   } mbb_cmd_type;

   typedef struct packed {
      logic load_last;
      logic scan_last;
      logic scan_land;
      logic queue_empty;
      logic nbr_last;
   } mbb_stat_type;

   // last index in use for a size register value: zero acts as one, oversize saturates
   function automatic int clamp_last(input int value, input int cap);
      int v;
      v = value;
      if (v == 0) begin
         v = 1;
      end else if (v > cap) begin
         v = cap;
      end
      return v - 1;
   endfunction

endpackage

// File: design/mbb_if.sv
// Channel interfaces: cell input, area result and register write.
`timescale 1ns / 1ps
interface mbb_req_if;
   logic valid;
   logic ready;
   logic cell_req;

   modport source (output valid, output cell_req, input ready);
   modport sink (input valid, input cell_req, output ready);
endinterface

interface mbb_rsp_if import mbb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [AREA_W-1:0] max_area;

   modport source (output valid, output max_area, input ready);
   modport sink (input valid, input max_area, output ready);
endinterface

interface mbb_csr_if import mbb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/mbb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module mbb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/mbb_dp.sv
// Datapath: size registers, position counters, grid store, visit queue and area tracking.
`timescale 1ns / 1ps
module mbb_dp import mbb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mbb_cmd_type          cmd,
   output mbb_stat_type         stat,
   input  logic                 cell_req,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data,
   output logic [AREA_W-1:0]    max_area
);

   logic [ROW_W-1:0]  row_last_ff, row_last_in;
   logic [COL_W-1:0]  col_last_ff, col_last_in;
   logic [ROW_W-1:0]  load_r_ff, load_r_in;
   logic [COL_W-1:0]  load_c_ff, load_c_in;
   logic [ROW_W-1:0]  scan_r_ff, scan_r_in;
   logic [COL_W-1:0]  scan_c_ff, scan_c_in;
   logic [ROW_W-1:0]  cur_r_ff, cur_r_in;
   logic [COL_W-1:0]  cur_c_ff, cur_c_in;
   logic [QCNT_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] tail_ff, tail_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [AREA_W-1:0] best_ff, best_in;
   logic [AREA_W-1:0] rsp_area_ff, rsp_area_in;
   logic [NBR_W-1:0]  nbr_k_ff, nbr_k_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0] chk_addr_ff, chk_addr_in;

   logic              load_last, scan_last, land_hit, nbr_ok;
   logic [ROW_W-1:0]  nbr_r;
   logic [COL_W-1:0]  nbr_c;
   logic [ADDR_W-1:0] load_addr, scan_addr, nbr_addr;

   logic              grid_we;
   logic [ADDR_W-1:0] grid_waddr, grid_raddr;
   logic [GRID_W-1:0] grid_wdata, grid_rdata;
   logic              q_we;
   logic [QIDX_W-1:0] q_waddr, q_raddr;
   logic [ADDR_W-1:0] q_wdata, q_rdata;

   assign load_last = (load_r_ff == row_last_ff) && (load_c_ff == col_last_ff);
   assign scan_last = (scan_r_ff == row_last_ff) && (scan_c_ff == col_last_ff);
   assign load_addr = {load_r_ff, load_c_ff};
   assign scan_addr = {scan_r_ff, scan_c_ff};

   // neighbor of the current cell, with its bounds check
   always_comb begin
      nbr_ok = 1'b0;
      nbr_r  = cur_r_ff;
      nbr_c  = cur_c_ff;
      case (nbr_k_ff)
         NBR_DOWN: begin
            nbr_ok = (cur_r_ff != row_last_ff);
            nbr_r  = cur_r_ff + ROW_W'(1);
         end
         NBR_UP: begin
            nbr_ok = (cur_r_ff != '0);
            nbr_r  = cur_r_ff - ROW_W'(1);
         end
         NBR_RIGHT: begin
            nbr_ok = (cur_c_ff != col_last_ff);
            nbr_c  = cur_c_ff + COL_W'(1);
         end
         NBR_LEFT: begin
            nbr_ok = (cur_c_ff != '0);
            nbr_c  = cur_c_ff - COL_W'(1);
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end
   assign nbr_addr = {nbr_r, nbr_c};

   // neighbor read last step came back as unvisited land
   assign land_hit = chk_valid_ff && (grid_rdata == GRID_LAND) && (tail_ff < QCNT_W'(CELL_CAP));

   assign grid_we    = cmd.load_cell || cmd.fill_start || (cmd.nbr_step && land_hit);
   assign grid_waddr = cmd.load_cell ? load_addr : (cmd.fill_start ? scan_addr : chk_addr_ff);
   assign grid_wdata = cmd.load_cell ? GRID_W'(cell_req) : GRID_VISITED;
   assign grid_raddr = cmd.scan_read ? scan_addr : nbr_addr;

   assign q_we    = cmd.fill_start || (cmd.nbr_step && land_hit);
   assign q_waddr = cmd.fill_start ? '0 : tail_ff[QIDX_W-1:0];
   assign q_wdata = cmd.fill_start ? scan_addr : chk_addr_ff;
   assign q_raddr = head_ff[QIDX_W-1:0];

   mbb_ram #(.WIDTH(GRID_W), .DEPTH(GRID_DEPTH)) u_grid (
      .clock (clock),
      .we    (grid_we),
      .waddr (grid_waddr),
      .wdata (grid_wdata),
      .raddr (grid_raddr),
      .rdata (grid_rdata)
   );

   mbb_ram #(.WIDTH(ADDR_W), .DEPTH(CELL_CAP)) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   always_comb begin
      row_last_in  = row_last_ff;
      col_last_in  = col_last_ff;
      load_r_in    = load_r_ff;
      load_c_in    = load_c_ff;
      scan_r_in    = scan_r_ff;
      scan_c_in    = scan_c_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      area_in      = area_ff;
      best_in      = best_ff;
      rsp_area_in  = rsp_area_ff;
      nbr_k_in     = nbr_k_ff;
      chk_valid_in = chk_valid_ff;
      chk_addr_in  = chk_addr_ff;

      // any known register write restarts loading at the first cell
      if (csr_write && ((csr_index == CSR_ROW_COUNT) || (csr_index == CSR_COLUMN_COUNT))) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_last_in = ROW_W'(clamp_last(int'(csr_data), MAX_ROWS));
         end else begin
            col_last_in = COL_W'(clamp_last(int'(csr_data), MAX_COLS));
         end
         load_r_in = '0;
         load_c_in = '0;
      end else if (cmd.load_cell) begin
         if (load_c_ff == col_last_ff) begin
            load_c_in = '0;
            load_r_in = load_last ? '0 : load_r_ff + ROW_W'(1);
         end else begin
            load_c_in = load_c_ff + COL_W'(1);
         end
      end

      if (cmd.scan_init) begin
         scan_r_in = '0;
         scan_c_in = '0;
         best_in   = '0;
      end else if (cmd.scan_next) begin
         if (scan_c_ff == col_last_ff) begin
            scan_c_in = '0;
            scan_r_in = scan_r_ff + ROW_W'(1);
         end else begin
            scan_c_in = scan_c_ff + COL_W'(1);
         end
      end

      if (cmd.fill_start) begin
         head_in = '0;
         tail_in = QCNT_W'(1);
         area_in = '0;
      end

      if (cmd.pop_read) begin
         head_in = head_ff + QCNT_W'(1);
      end

      if (cmd.pop_latch) begin
         cur_r_in     = q_rdata[ADDR_W-1:COL_W];
         cur_c_in     = q_rdata[COL_W-1:0];
         nbr_k_in     = NBR_DOWN;
         chk_valid_in = 1'b0;
         if (area_ff != AREA_W'(AREA_MAX)) begin
            area_in = area_ff + AREA_W'(1);
         end
      end

      if (cmd.nbr_step) begin
         nbr_k_in     = nbr_k_ff + NBR_W'(1);
         chk_valid_in = nbr_ok;
         chk_addr_in  = nbr_addr;
         if (land_hit) begin
            tail_in = tail_ff + QCNT_W'(1);
         end
      end

      if (cmd.comp_done && (area_ff > best_ff)) begin
         best_in = area_ff;
      end

      if (cmd.rsp_load) begin
         rsp_area_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff  <= ROW_W'(clamp_last(ROW_COUNT_RESET, MAX_ROWS));
         col_last_ff  <= COL_W'(clamp_last(COL_COUNT_RESET, MAX_COLS));
         load_r_ff    <= '0;
         load_c_ff    <= '0;
         scan_r_ff    <= '0;
         scan_c_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         area_ff      <= '0;
         best_ff      <= '0;
         nbr_k_ff     <= NBR_DOWN;
         chk_valid_ff <= 1'b0;
      end else begin
         row_last_ff  <= row_last_in;
         col_last_ff  <= col_last_in;
         load_r_ff    <= load_r_in;
         load_c_ff    <= load_c_in;
         scan_r_ff    <= scan_r_in;
         scan_c_ff    <= scan_c_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         area_ff      <= area_in;
         best_ff      <= best_in;
         nbr_k_ff     <= nbr_k_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      rsp_area_ff <= rsp_area_in;
      chk_addr_ff <= chk_addr_in;
   end

   assign stat.load_last   = load_last;
   assign stat.scan_last   = scan_last;
   assign stat.scan_land   = (grid_rdata == GRID_LAND);
   assign stat.queue_empty = (head_ff == tail_ff);
   assign stat.nbr_last    = (nbr_k_ff == NBR_END);
   assign max_area         = rsp_area_ff;

   a_queue_order : assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("visit queue read pointer passed write pointer");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      tail_ff <= QCNT_W'(CELL_CAP))
      else $error("visit queue overfilled");

endmodule

// File: design/mbb_ctrl.sv
// Controller: load, scan and flood-fill sequencing, result handshake.
`timescale 1ns / 1ps
module mbb_ctrl import mbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  mbb_stat_type stat,
   output mbb_cmd_type  cmd
);

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK = 3'd2;
   localparam logic [2:0] ST_POP      = 3'd3;
   localparam logic [2:0] ST_POP_WAIT = 3'd4;
   localparam logic [2:0] ST_NBR      = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // the last cell waits until the previous result is taken
   assign req_ready = (state_ff == ST_LOAD) && !(stat.load_last && rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load_cell = 1'b1;
               if (stat.load_last) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (stat.scan_land) begin
               cmd.fill_start = 1'b1;
               state_in       = ST_POP;
            end else if (stat.scan_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_POP: begin
            if (stat.queue_empty) begin
               cmd.comp_done = 1'b1;
               if (stat.scan_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in      = ST_SCAN_RD;
               end
            end else begin
               cmd.pop_read = 1'b1;
               state_in     = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cmd.pop_latch = 1'b1;
            state_in      = ST_NBR;
         end
         ST_NBR: begin
            cmd.nbr_step = 1'b1;
            if (stat.nbr_last) begin
               state_in = ST_POP;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !rsp_valid_ff)
      else $error("result loaded while previous result still pending");

   a_done_presents : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid_ff && (state_ff == ST_LOAD)))
      else $error("finished scan did not present a result");

endmodule

// File: design/max_blob_area_bfs.sv
// Top level: largest 4-connected land area of a streamed binary grid.
//
//   port      dir  transaction payload       notes
//   req_chan  in   cell_req (1b)             one grid cell, row-major
//   rsp_chan  out  max_area (13b)            one result per complete grid
//   csr_chan  in   index (2b), data (7b)     0 row_count, 1 column_count
//
// Sequence: cells load one per cycle while the block is in its load state and
//   not stalled. After the last cell the scan reads the grid store, then checks,
//   for each grid cell; for each land cell flooded it pops and reads the queue,
//   then takes five neighbor steps through the single grid read port; then it posts the result.
// Reset: synchronous, sizes return to 64 x 64, load restarts at cell 0;
//   grid store and visit queue are not cleared (every cell is written first).
// Stalls: while a result waits on rsp_chan, loading continues up to but not
//   including the last cell of the next grid. csr_chan is always ready.
`timescale 1ns / 1ps
module max_blob_area_bfs import mbb_pkg::*; (
   input logic           clock,
   input logic           reset,
   mbb_req_if.sink       req_chan,
   mbb_rsp_if.source     rsp_chan,
   mbb_csr_if.sink       csr_chan
);

   mbb_cmd_type  cmd;
   mbb_stat_type stat;
   logic         csr_write;

   // register writes go straight into the size registers, so the port never pushes back
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   // sequencing: load, scan, flood fill, post result
   mbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, counters and area bookkeeping
   mbb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .cell_req  (req_chan.cell_req),
      .csr_write (csr_write),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .max_area  (rsp_chan.max_area)
   );

endmodule

// File: tb/sv/tb.sv
// Testbench for max_blob_area_bfs: streamed grids, flood-fill area prediction and scoreboard.
`timescale 1ns / 1ps
module tb;
   import mbb_pkg::*;

   // Pause before a register write, once no result is pending, so that a short
   // pause covers any cell still in flight.
   localparam int SETTLE_CYCLES   = 16;
   // Quiet time at the end, long enough to catch a stray extra result.
   localparam int DRAIN_CYCLES    = 200;
   // Longest silent stretch: a 256-cell scan of all land, behind a receiver
   // hold-off and random stalls, with a wide margin.
   localparam int WATCHDOG_LIMIT  = 20000;
   // Receiver hold-off for the backpressure test: far longer than loading
   // and scanning a 3x3 grid, so the block fills and stops taking cells.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_PRINTED     = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbb_req_if req_chan ();
   mbb_rsp_if rsp_chan ();
   mbb_csr_if csr_chan ();

   max_blob_area_bfs u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Traffic shaping knobs, set by the test tasks
   // ---------------------------------------------------------------------
   int src_idle_pct  = 0;   // chance per cycle the sender holds back
   int sink_stall_pct = 0;  // chance per cycle the receiver drops ready
   int hold_off_left = 0;   // receiver hold-off, counted down below

   // Sizes as last written, stimulus side; used to size the grids sent and to rewrite a size.
   int rows_set = ROW_COUNT_RESET;
   int cols_set = COL_COUNT_RESET;

   // ---------------------------------------------------------------------
   // Predictor state: size registers, load pointer and the loaded grid.
   // ---------------------------------------------------------------------
   logic [SIZE_W-1:0] pred_rows_reg;
   logic [SIZE_W-1:0] pred_cols_reg;
   int unsigned       pred_load_pos;
   bit                land_map [CELL_CAP];

   // Expected max_area values, oldest first.
   logic [AREA_W-1:0] area_expect_q [$];

   int unsigned error_count  = 0;
   int unsigned quiet_cycles = 0;

   // Size register value to rows or columns in use: zero acts as one,
   // anything above the cap acts as the cap.
   function automatic int size_in_use(input int raw, input int cap);
      if (raw == 0) begin
         return 1;
      end
      if (raw > cap) begin
         return cap;
      end
      return raw;
   endfunction

   function automatic int grid_cells();
      return size_in_use(rows_set, MAX_ROWS) * size_in_use(cols_set, MAX_COLS);
   endfunction

   // Largest 4-connected land area of the loaded rows x cols grid.
   // Breadth-first fill from each unvisited land cell, row-major scan.
   function automatic logic [AREA_W-1:0] largest_blob_area(input int rows, input int cols);
      bit seen [CELL_CAP];
      int fifo [CELL_CAP];
      int dr [4] = '{1, -1, 0, 0};
      int dc [4] = '{0, 0, 1, -1};
      int head;
      int tail;
      int spot;
      int r;
      int c;
      int nr;
      int nc;
      int nidx;
      int area;
      int best;
      best = 0;
      for (int start = 0; start < rows * cols; start++) begin
         if (land_map[start] && !seen[start]) begin
            head = 0;
            tail = 1;
            area = 0;
            seen[start] = 1'b1;
            fifo[0] = start;
            while (head < tail) begin
               spot = fifo[head];
               head++;
               r = spot / cols;
               c = spot % cols;
               if (area < AREA_MAX) begin
                  area++;
               end
               for (int k = 0; k < 4; k++) begin
                  nr = r + dr[k];
                  nc = c + dc[k];
                  if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                     nidx = nr * cols + nc;
                     if (land_map[nidx] && !seen[nidx]) begin
                        seen[nidx] = 1'b1;
                        fifo[tail] = nidx;
                        tail++;
                     end
                  end
               end
            end
            if (area > best) begin
               best = area;
            end
         end
      end
      return AREA_W'(best);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("%0t ns mismatch: %s", $time, what);
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: every transaction is sampled at the rising edge, before any
   // nonblocking update of that edge lands. Results are checked first, then
   // register writes and cells feed the predictor.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int rows_now;
      int cols_now;
      logic [AREA_W-1:0] want;
      if (reset) begin
         pred_rows_reg = SIZE_W'(ROW_COUNT_RESET);
         pred_cols_reg = SIZE_W'(COL_COUNT_RESET);
         pred_load_pos = 0;
         quiet_cycles  = 0;
      end else begin
         quiet_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            quiet_cycles = 0;
            if (area_expect_q.size() == 0) begin
               report_mismatch($sformatf("result max_area=%0d with none expected",
                                         rsp_chan.max_area));
            end else begin
               want = area_expect_q.pop_front();
               if (rsp_chan.max_area !== want) begin
                  report_mismatch($sformatf("max_area=%0d, expected %0d",
                                            rsp_chan.max_area, want));
               end
            end
         end
         // any size write restarts loading at cell 0
         if (csr_chan.valid && csr_chan.ready) begin
            quiet_cycles = 0;
            case (csr_chan.index)
               CSR_ROW_COUNT: begin
                  pred_rows_reg = csr_chan.data;
                  pred_load_pos = 0;
               end
               CSR_COLUMN_COUNT: begin
                  pred_cols_reg = csr_chan.data;
                  pred_load_pos = 0;
               end
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            quiet_cycles = 0;
            rows_now = size_in_use(pred_rows_reg, MAX_ROWS);
            cols_now = size_in_use(pred_cols_reg, MAX_COLS);
            if (pred_load_pos >= rows_now * cols_now) begin
               pred_load_pos = 0;
            end
            land_map[pred_load_pos] = req_chan.cell_req;
            pred_load_pos++;
            // last cell of the grid: one result, the largest area or 0
            if (pred_load_pos == rows_now * cols_now) begin
               pred_load_pos = 0;
               area_expect_q.push_back(largest_blob_area(rows_now, cols_now));
            end
         end
      end
   end

   // Receiver: random stalls, or a solid hold-off while one is requested.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   initial begin
      @(negedge reset);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[max_blob_area_bfs] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One cell transaction. Valid stays high from one cell to the next unless
   // a random gap drops it.
   task automatic send_cell(input bit land);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cell_req <= land;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // Cells given MSB first, so a literal reads in row-major order.
   task automatic send_bits(input logic [63:0] bits, input int count);
      for (int i = count - 1; i >= 0; i--) begin
         send_cell(bits[i]);
      end
   endtask

   task automatic send_grid(input int land_pct);
      int count;
      count = grid_cells();
      repeat (count) begin
         send_cell($urandom_range(99) < land_pct);
      end
   endtask

   // Idle point: sender quiet, every expected result back, then a short
   // pause so a partly loaded grid is settled before a register write.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (area_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      if (idx == CSR_ROW_COUNT) begin
         rows_set = value;
      end else begin
         cols_set = value;
      end
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= SIZE_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input int rows, input int cols);
      wait_idle();
      write_reg(CSR_ROW_COUNT, rows);
      write_reg(CSR_COLUMN_COUNT, cols);
   endtask

   function automatic int pick_land_pct();
      case ($urandom_range(5))
         0: return 0;
         1: return 20;
         2: return 50;
         3: return 60;
         4: return 80;
         default: return 100;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset sizes are 64 x 64: a few cells load with no result, then a size
   // write drops them and a 1x1 grid (zero sizes act as one) starts fresh.
   task automatic test_reset_and_restart();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      send_bits(5'b10110, 5);
      set_size(0, 0);
      send_bits(1'b1, 1);
      send_bits(1'b0, 1);
   endtask

   // Small hand-made grids: full block, diagonal only (no 8-connectivity),
   // restart by a single column write, and a ring around a water hole.
   task automatic test_small_shapes();
      set_size(2, 2);
      send_bits(4'b11_11, 4);
      send_bits(4'b10_01, 4);
      send_bits(2'b11, 2);
      wait_idle();
      write_reg(CSR_COLUMN_COUNT, 2);
      send_bits(4'b01_10, 4);
      set_size(3, 3);
      send_bits(9'b111_101_111, 9);
   endtask

   // Size extremes: single row and column at the cap, oversize values that
   // saturate, and a zero beside a full-height column.
   task automatic test_size_extremes();
      src_idle_pct   = 15;
      sink_stall_pct = 15;
      set_size(1, 64);
      send_grid(70);
      set_size(64, 1);
      send_grid(70);
      set_size(127, 2);
      send_grid(60);
      set_size(2, 127);
      send_grid(60);
      set_size(64, 0);
      send_grid(50);
      wait_idle();
   endtask

   // Receiver holds off for a long stretch while grids keep coming, so a
   // result waits and the block stops taking cells of the next grid.
   task automatic test_backpressure();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      set_size(3, 3);
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (4) begin
         send_grid(70);
      end
      wait_idle();
   endtask

   // Mostly whole grids of random size and land density; now and then a
   // grid cut short and abandoned by a size write.
   task automatic test_random_phase(input int src_pct, input int sink_pct, input int budget);
      int sent;
      int count;
      int cut;
      int rows;
      int cols;
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) == 0) begin
               // one dimension anywhere in the register range, other kept small
               rows = $urandom_range(127);
               cols = $urandom_range(4, 1);
               if ($urandom_range(1)) begin
                  set_size(cols, rows);
               end else begin
                  set_size(rows, cols);
               end
            end else if ($urandom_range(1)) begin
               set_size($urandom_range(8, 1), $urandom_range(8, 1));
            end else begin
               wait_idle();
               if ($urandom_range(1)) begin
                  write_reg(CSR_ROW_COUNT, $urandom_range(8, 1));
               end else begin
                  write_reg(CSR_COLUMN_COUNT, $urandom_range(8, 1));
               end
            end
         end
         count = grid_cells();
         if (count > 1 && $urandom_range(99) < 8) begin
            cut = $urandom_range(count - 1, 1);
            repeat (cut) begin
               send_cell($urandom_range(1));
            end
            sent += cut;
            wait_idle();
            if ($urandom_range(1)) begin
               write_reg(CSR_ROW_COUNT, rows_set);
            end else begin
               write_reg(CSR_COLUMN_COUNT, cols_set);
            end
         end else begin
            send_grid(pick_land_pct());
            sent += count;
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid    = 1'b0;
      req_chan.cell_req = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = CSR_ROW_COUNT;
      csr_chan.data     = '0;
      rsp_chan.ready    = 1'b0;
      repeat (3) begin
         @(posedge clock);
      end
      reset <= 1'b0;
      @(posedge clock);

      test_reset_and_restart();
      test_small_shapes();
      test_size_extremes();
      test_backpressure();
      test_random_phase(0, 0, 210);
      test_random_phase(47, 0, 210);
      test_random_phase(0, 47, 210);
      test_random_phase(15, 15, 210);

      wait_idle();
      repeat (DRAIN_CYCLES) begin
         @(posedge clock);
      end
      if (error_count == 0 && area_expect_q.size() == 0) begin
         $display("[max_blob_area_bfs] OK");
      end else begin
         $display("[max_blob_area_bfs] ERROR");
      end
      $finish;
   end

endmodule
